/* rtl/fealcbc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fealcbc_pkg
// Shared types, register map and byte-wise mixing functions of the
// FEAL-style Feistel cipher with ECB and CBC modes.
// ----------------------------------------------------------------------------
package fealcbc_pkg;

    // Largest supported round count and the subkey store that it needs.
    localparam int MAX_ROUNDS = 8;
    localparam int KEY_WORDS  = (MAX_ROUNDS + 8) / 2;
    localparam int KADDR_W    = $clog2(KEY_WORDS);
    localparam int RCNT_W     = 4;

    // Configuration port.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;

    // Register indexes (paddr[4:3]).
    localparam logic [1:0] REG_KEY_LEFT    = 2'd0;
    localparam logic [1:0] REG_KEY_RIGHT   = 2'd1;
    localparam logic [1:0] REG_ROUND_COUNT = 2'd2;
    localparam logic [1:0] REG_INIT_VECTOR = 2'd3;

    localparam logic [RCNT_W-1:0] ROUND_COUNT_RESET = 4'd8;

    // Operating modes.
    localparam logic [1:0] MODE_ECB_ENC = 2'd0;
    localparam logic [1:0] MODE_ECB_DEC = 2'd1;
    localparam logic [1:0] MODE_CBC_ENC = 2'd2;
    localparam logic [1:0] MODE_CBC_DEC = 2'd3;

    // Which right-key term the schedule mixes in at a given step.
    typedef enum logic [1:0] {
        KX_Q,
        KX_KR1,
        KX_KR2
    } fealcbc_kx_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic               load;
        logic               sched_step;
        logic               sched_first;
        logic [KADDR_W-1:0] sched_idx;
        logic               sched_done;
        logic               round_step;
        logic               finish;
        logic [KADDR_W-1:0] key_raddr;
    } fealcbc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic reverse;
    } fealcbc_stat_t;

    // Step index modulo three, as a small table.
    function automatic fealcbc_kx_t kx_select(input logic [KADDR_W-1:0] idx);
        fealcbc_kx_t sel;
        case (idx)
            3'd0, 3'd3, 3'd6: sel = KX_Q;
            3'd1, 3'd4, 3'd7: sel = KX_KR1;
            default:          sel = KX_KR2;
        endcase
        return sel;
    endfunction

    // Round function F: byte adds with no rotation, top two key bytes only.
    function automatic logic [31:0] round_fn(input logic [31:0] d, input logic [31:0] k);
        logic [7:0] f1;
        logic [7:0] f2;
        f1 = d[23:16] ^ k[31:24] ^ d[31:24];
        f2 = d[15:8] ^ k[23:16] ^ d[7:0];
        f1 = f1 + f2 + 8'd1;
        f2 = f2 + f1;
        return {d[31:24] + f1, f1, f2, d[7:0] + f2 + 8'd1};
    endfunction

    // Key function Fk.
    function automatic logic [31:0] key_fn(input logic [31:0] a, input logic [31:0] b);
        logic [7:0] f1;
        logic [7:0] f2;
        f1 = a[23:16] ^ a[31:24];
        f2 = a[15:8] ^ a[7:0];
        f1 = f1 + (f2 ^ b[31:24]) + 8'd1;
        f2 = f2 + (f1 ^ b[23:16]);
        return {a[31:24] + (f1 ^ b[15:8]), f1, f2, a[7:0] + (f2 ^ b[7:0]) + 8'd1};
    endfunction

endpackage

/* rtl/fealcbc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fealcbc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fealcbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/fealcbc_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fealcbc_regs
// Configuration register file behind the APB-style port, plus the flag that
// tells whether the stored subkeys match the current key and round count.
// ----------------------------------------------------------------------------
module fealcbc_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fealcbc_pkg::PADDR_W-1:0]  paddr,
    input  logic [fealcbc_pkg::PDATA_W-1:0]  pwdata,
    output logic [fealcbc_pkg::PDATA_W-1:0]  prdata,
    output logic                             pready,
    input  logic                             sched_done,
    output logic [63:0]                      key_left,
    output logic [63:0]                      key_right,
    output logic [63:0]                      init_vector,
    output logic [fealcbc_pkg::RCNT_W-1:0]   eff_rounds,
    output logic                             sched_ready
);

    logic [63:0]                    key_left_reg;
    logic [63:0]                    key_right_reg;
    logic [63:0]                    init_vector_reg;
    logic [fealcbc_pkg::RCNT_W-1:0] round_count_reg;
    logic                           sched_ready_reg;
    logic                           wr_en;
    logic [1:0]                     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:3];

    // Register writes; a key or round change invalidates the subkeys.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_left_reg    <= '0;
            key_right_reg   <= '0;
            init_vector_reg <= '0;
            round_count_reg <= fealcbc_pkg::ROUND_COUNT_RESET;
            sched_ready_reg <= 1'b0;
        end
        else
        begin
            if (sched_done)
            begin
                sched_ready_reg <= 1'b1;
            end
            if (wr_en)
            begin
                case (reg_idx)
                    fealcbc_pkg::REG_KEY_LEFT:
                    begin
                        key_left_reg    <= pwdata;
                        sched_ready_reg <= 1'b0;
                    end
                    fealcbc_pkg::REG_KEY_RIGHT:
                    begin
                        key_right_reg   <= pwdata;
                        sched_ready_reg <= 1'b0;
                    end
                    fealcbc_pkg::REG_ROUND_COUNT:
                    begin
                        round_count_reg <= pwdata[fealcbc_pkg::RCNT_W-1:0];
                        sched_ready_reg <= 1'b0;
                    end
                    default:
                    begin
                        init_vector_reg <= pwdata;
                    end
                endcase
            end
        end
    end

    // Read back.
    always_comb
    begin
        case (reg_idx)
            fealcbc_pkg::REG_KEY_LEFT:    prdata = key_left_reg;
            fealcbc_pkg::REG_KEY_RIGHT:   prdata = key_right_reg;
            fealcbc_pkg::REG_ROUND_COUNT: prdata = 64'(round_count_reg);
            default:                      prdata = init_vector_reg;
        endcase
    end

    // Clamp the round count into 1..MAX_ROUNDS.
    always_comb
    begin
        if (round_count_reg == '0)
        begin
            eff_rounds = fealcbc_pkg::RCNT_W'(1);
        end
        else if (round_count_reg > fealcbc_pkg::RCNT_W'(fealcbc_pkg::MAX_ROUNDS))
        begin
            eff_rounds = fealcbc_pkg::RCNT_W'(fealcbc_pkg::MAX_ROUNDS);
        end
        else
        begin
            eff_rounds = round_count_reg;
        end
    end

    assign key_left    = key_left_reg;
    assign key_right   = key_right_reg;
    assign init_vector = init_vector_reg;
    assign sched_ready = sched_ready_reg;

endmodule

/* rtl/fealcbc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fealcbc_ctrl
// Controller: sequences the key schedule, the rounds and the hand-off of
// each finished item to the output register.
// ----------------------------------------------------------------------------
module fealcbc_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    output logic                            out_valid,
    input  logic                            out_stall,
    input  logic [fealcbc_pkg::RCNT_W-1:0]  eff_rounds,
    input  logic                            sched_ready,
    input  fealcbc_pkg::fealcbc_stat_t      stat,
    output fealcbc_pkg::fealcbc_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCHED,
        ST_PREFETCH,
        ST_ROUND,
        ST_FINISH
    } state_t;

    state_t                              state_reg;
    logic [fealcbc_pkg::KADDR_W-1:0]     cnt_reg;
    logic                                out_valid_reg;

    logic [fealcbc_pkg::RCNT_W:0]        words_sum;
    logic [fealcbc_pkg::KADDR_W-1:0]     words_m1;
    logic [fealcbc_pkg::KADDR_W-1:0]     rounds_m1;
    logic [fealcbc_pkg::KADDR_W-1:0]     key_idx;
    logic                                accept;
    logic                                finish;

    // Last subkey word index and last round index.
    assign words_sum = (fealcbc_pkg::RCNT_W+1)'(eff_rounds) + (fealcbc_pkg::RCNT_W+1)'(8);
    assign words_m1  = fealcbc_pkg::KADDR_W'((words_sum >> 1) - 1'b1);
    assign rounds_m1 = fealcbc_pkg::KADDR_W'(eff_rounds - 1'b1);

    assign accept = (state_reg == ST_IDLE) && in_valid;
    assign finish = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    // Subkey index for the round fetched next; decrypt walks backwards.
    always_comb
    begin
        logic [fealcbc_pkg::KADDR_W-1:0] k;
        k = (state_reg == ST_ROUND) ? cnt_reg + 1'b1 : '0;
        key_idx = stat.reverse ? rounds_m1 - k : k;
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd             = '0;
        cmd.load        = accept;
        cmd.sched_step  = (state_reg == ST_SCHED);
        cmd.sched_first = (cnt_reg == '0);
        cmd.sched_idx   = cnt_reg;
        cmd.sched_done  = (state_reg == ST_SCHED) && (cnt_reg == words_m1);
        cmd.round_step  = (state_reg == ST_ROUND);
        cmd.finish      = finish;
        cmd.key_raddr   = key_idx;
    end

    // State, step counter and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (in_valid)
                    begin
                        state_reg <= sched_ready ? ST_PREFETCH : ST_SCHED;
                    end
                end
                ST_SCHED:
                begin
                    if (cnt_reg == words_m1)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_PREFETCH;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_PREFETCH:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_ROUND;
                end
                ST_ROUND:
                begin
                    if (cnt_reg == rounds_m1)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_FINISH:
                begin
                    if (finish)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* rtl/fealcbc_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fealcbc_dp
// Datapath: CBC chaining, the shared key-schedule step, the shared round
// unit and the output register.
// ----------------------------------------------------------------------------
module fealcbc_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fealcbc_pkg::fealcbc_cmd_t         cmd,
    output fealcbc_pkg::fealcbc_stat_t        stat,
    input  logic [1:0]                        mode,
    input  logic [63:0]                       data_block,
    input  logic                              first_of_message,
    input  logic [63:0]                       key_left,
    input  logic [63:0]                       key_right,
    input  logic [63:0]                       init_vector,
    output logic                              key_we,
    output logic [fealcbc_pkg::KADDR_W-1:0]   key_waddr,
    output logic [31:0]                       key_wdata,
    input  logic [31:0]                       key_rdata,
    output logic [63:0]                       result_block
);

    logic [1:0]  mode_reg;
    logic [31:0] l_reg;
    logic [31:0] r_reg;
    logic [63:0] chain_reg;
    logic [63:0] chain_used_reg;
    logic [63:0] data_reg;
    logic [63:0] result_reg;
    logic [31:0] ka_reg;
    logic [31:0] kb_reg;
    logic [31:0] kd_reg;

    logic [63:0] chain_sel;
    logic [63:0] blk_in;
    logic [31:0] q_term;
    logic [31:0] x_term;
    logic [31:0] ka_next;
    logic [63:0] res_next;

    // Chain value for this item: the init vector on the first CBC block.
    assign chain_sel = (mode[1] && first_of_message) ? init_vector : chain_reg;
    assign blk_in    = (mode == fealcbc_pkg::MODE_CBC_ENC) ? (data_block ^ chain_sel)
                                                           : data_block;

    // One schedule step: pick the right-key term, fold in d, apply Fk.
    assign q_term = key_right[63:32] ^ key_right[31:0];
    always_comb
    begin
        case (fealcbc_pkg::kx_select(cmd.sched_idx))
            fealcbc_pkg::KX_Q:   x_term = kb_reg ^ q_term;
            fealcbc_pkg::KX_KR1: x_term = kb_reg ^ key_right[63:32];
            default:             x_term = kb_reg ^ key_right[31:0];
        endcase
        if (!cmd.sched_first)
        begin
            x_term = x_term ^ kd_reg;
        end
    end
    assign ka_next = fealcbc_pkg::key_fn(ka_reg, x_term);

    assign key_we    = cmd.sched_step;
    assign key_waddr = cmd.sched_idx;
    assign key_wdata = ka_next;

    // Result: the two halves swapped, XORed with the chain value for CBC decrypt.
    assign res_next = (mode_reg == fealcbc_pkg::MODE_CBC_DEC) ? ({r_reg, l_reg} ^ chain_used_reg)
                                                             : {r_reg, l_reg};

    // Item, schedule and round registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg       <= mode;
            l_reg          <= blk_in[63:32];
            r_reg          <= blk_in[31:0];
            chain_used_reg <= chain_sel;
            data_reg       <= data_block;
            ka_reg         <= key_left[63:32];
            kb_reg         <= key_left[31:0];
            kd_reg         <= key_left[63:32];
        end
        else
        begin
            if (cmd.sched_step)
            begin
                kd_reg <= ka_reg;
                ka_reg <= kb_reg;
                kb_reg <= ka_next;
            end
            if (cmd.round_step)
            begin
                l_reg <= r_reg;
                r_reg <= l_reg ^ fealcbc_pkg::round_fn(r_reg, key_rdata);
            end
        end
        if (cmd.finish)
        begin
            result_reg <= res_next;
        end
    end

    // CBC chain: ciphertext out on encrypt, ciphertext in on decrypt.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= '0;
        end
        else if (cmd.finish)
        begin
            if (mode_reg == fealcbc_pkg::MODE_CBC_ENC)
            begin
                chain_reg <= res_next;
            end
            else if (mode_reg == fealcbc_pkg::MODE_CBC_DEC)
            begin
                chain_reg <= data_reg;
            end
        end
    end

    assign stat.reverse = mode_reg[0];
    assign result_block = result_reg;

endmodule

/* rtl/feal_style_feistel_cipher_cbc_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feal_style_feistel_cipher_cbc_top
// FEAL-style 64-bit Feistel block cipher with ECB and CBC modes.
// ----------------------------------------------------------------------------
// One item is one 64-bit block and gives one 64-bit result. The block works
// on one item at a time through a single shared round unit. After it is
// accepted, an item passes through a subkey prefetch from the subkey RAM,
// the rounds and the hand-off to the output register, and the next item is
// taken only once the block is idle again after that hand-off. A round count
// of zero runs as one round and a count above eight runs as eight. After a
// write to key_left, key_right or round_count the first item also runs the
// key schedule, one subkey word per cycle, for (round_count + 8) / 2 subkey
// words. The next item is taken while a result still waits in the output
// register; its hand-off then waits until that result leaves. The CBC chain
// reloads from init_vector when first_of_message is set in a CBC mode.
// ----------------------------------------------------------------------------
module feal_style_feistel_cipher_cbc_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      mode,
    input  logic [63:0]                     data_block,
    input  logic                            first_of_message,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [63:0]                     result_block,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fealcbc_pkg::PADDR_W-1:0] paddr,
    input  logic [fealcbc_pkg::PDATA_W-1:0] pwdata,
    output logic [fealcbc_pkg::PDATA_W-1:0] prdata,
    output logic                            pready
);

    fealcbc_pkg::fealcbc_cmd_t       cmd;
    fealcbc_pkg::fealcbc_stat_t      stat;
    logic [63:0]                     key_left;
    logic [63:0]                     key_right;
    logic [63:0]                     init_vector;
    logic [fealcbc_pkg::RCNT_W-1:0]  eff_rounds;
    logic                            sched_ready;
    logic                            key_we;
    logic [fealcbc_pkg::KADDR_W-1:0] key_waddr;
    logic [31:0]                     key_wdata;
    logic [31:0]                     key_rdata;

    fealcbc_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .sched_done  (cmd.sched_done),
        .key_left    (key_left),
        .key_right   (key_right),
        .init_vector (init_vector),
        .eff_rounds  (eff_rounds),
        .sched_ready (sched_ready)
    );

    fealcbc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .eff_rounds  (eff_rounds),
        .sched_ready (sched_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    fealcbc_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .mode             (mode),
        .data_block       (data_block),
        .first_of_message (first_of_message),
        .key_left         (key_left),
        .key_right        (key_right),
        .init_vector      (init_vector),
        .key_we           (key_we),
        .key_waddr        (key_waddr),
        .key_wdata        (key_wdata),
        .key_rdata        (key_rdata),
        .result_block     (result_block)
    );

    // Subkey store.
    fealcbc_ram #(
        .WIDTH (32),
        .DEPTH (fealcbc_pkg::KEY_WORDS)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (cmd.key_raddr),
        .rdata (key_rdata)
    );

endmodule

/* rtl/fealcbc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fealcbc_checker
// Port-level checks of the cipher's item handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module fealcbc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] result_block
);

    // A waiting result is not dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A waiting result does not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(result_block))
        else $error("result changed while stalled");

    // One item at a time: the input closes right after an item is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while one is in flight");

    // A new result only appears at the end of an item's work.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with no item in flight");

endmodule

bind feal_style_feistel_cipher_cbc_top fealcbc_checker u_fealcbc_checker (.*);
